@@ design/bspd_pkg.sv @@
// Package for the byte stream packet deframer.
// Holds framing constants, queue sizing and the result word type; no dependencies.
package bspd_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int TERM_BYTES   = 4;
    localparam int WIN_DEPTH    = TERM_BYTES - 1;

    localparam logic [7:0]  BINARY_START = 8'h24;
    localparam logic [31:0] TERM_RESET   = 32'h0D0A_0D0A;

    localparam logic KIND_BINARY = 1'b0;
    localparam logic KIND_TEXT   = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       packet_kind;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ design/bspd_if.sv @@
// Handshake interfaces for the deframer: input byte, result word and terminator write.
// Depends on nothing; each carries valid, ready and its payload.
interface bspd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bspd_result_if;
    logic       valid;
    logic       ready;
    logic       packet_kind;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, output packet_kind, output payload_byte,
                    output byte_valid, output last, input ready);
    modport sink   (input valid, input packet_kind, input payload_byte,
                    input byte_valid, input last, output ready);
endinterface

interface bspd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/byte_stream_packet_deframer_top.sv @@
// Top level of the byte stream packet deframer.
// Depends on bspd_pkg, bspd_if, bspd_front, bspd_queue and bspd_back.
//
//   port    dir  word                                            handshake
//   i_in    in   in_byte                                         valid/ready
//   o_out   out  packet_kind, payload_byte, byte_valid, last     valid/ready
//   i_cfg   in   data (text_terminator)                          valid/ready
//
// One byte is taken per cycle while the queue is not full; a result word is written
// to the queue at its byte's edge, then loaded into the output register that
// drives o_out.
// The front end's combinational framing state update sets that rate.
// Reset is synchronous and active low; no clearing pass.
// A stalled output fills the four-word queue; i_in.ready drops only when full.
module byte_stream_packet_deframer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bspd_byte_if.sink    i_in,
    bspd_result_if.source o_out,
    bspd_cfg_if.sink     i_cfg
);
    bspd_pkg::t_queue_status q_status;
    bspd_pkg::t_result       front_result;
    bspd_pkg::t_result       q_data;
    bspd_pkg::t_result       out_data;
    logic                    push;
    logic                    pop;

    assign i_cfg.ready = 1'b1;

    bspd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_byte  (i_in.in_byte),
        .o_in_ready (i_in.ready),
        .i_cfg_valid(i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_result   (front_result)
    );

    bspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_result),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_status(q_status)
    );

    bspd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_out_data (out_data)
    );

    assign o_out.packet_kind  = out_data.packet_kind;
    assign o_out.payload_byte = out_data.payload_byte;
    assign o_out.byte_valid   = out_data.byte_valid;
    assign o_out.last         = out_data.last;

endmodule

@@ design/bspd_front.sv @@
// Front end of the deframer: framing state machine, terminator register and text window.
// Uses bspd_pkg; turns each accepted byte into at most one result word for the queue.
module bspd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [7:0]              i_in_byte,
    output logic                    o_in_ready,
    input  logic                    i_cfg_valid,
    input  logic [31:0]             i_cfg_data,
    input  bspd_pkg::t_queue_status i_q_status,
    output logic                    o_push,
    output bspd_pkg::t_result       o_result
);
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_TEXT    = 2'd3;
    localparam int FILL_W = $clog2(bspd_pkg::TERM_BYTES);
    localparam logic [2:0] HDR_LAST = 3'(bspd_pkg::HEADER_BYTES - 1);

    logic [31:0]       r_term;
    logic [1:0]        r_mode, n_mode;
    logic [2:0]        r_hc, n_hc;
    logic [31:0]       r_rem, n_rem;
    logic [7:0]        r_win [bspd_pkg::WIN_DEPTH];
    logic [7:0]        n_win [bspd_pkg::WIN_DEPTH];
    logic [FILL_W-1:0] r_fill, n_fill;

    logic        in_fire;
    logic [2:0]  hc_m1;
    logic [4:0]  shamt;
    logic [31:0] seq;

    assign o_in_ready = !i_q_status.full;
    assign in_fire    = i_in_valid && o_in_ready;
    assign hc_m1      = r_hc - 3'd1;
    assign shamt      = {hc_m1[1:0], 3'b000};
    assign seq        = {r_win[0], r_win[1], r_win[2], i_in_byte};

    always_comb begin
        n_mode   = r_mode;
        n_hc     = r_hc;
        n_rem    = r_rem;
        n_win    = r_win;
        n_fill   = r_fill;
        o_push   = 1'b0;
        o_result = '0;
        if (in_fire) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (i_in_byte == bspd_pkg::BINARY_START) begin
                        n_mode = MODE_HEADER;
                        n_hc   = 3'd1;
                        n_rem  = '0;
                    end else begin
                        // first byte already belongs to the text
                        n_mode   = MODE_TEXT;
                        n_win[0] = i_in_byte;
                        n_fill   = FILL_W'(1);
                    end
                end
                MODE_HEADER: begin
                    n_rem = r_rem | (32'(i_in_byte) << shamt);
                    n_hc  = r_hc + 3'd1;
                    if (r_hc == HDR_LAST) begin
                        n_hc = '0;
                        if (n_rem == '0) begin
                            n_mode   = MODE_IDLE;
                            o_push   = 1'b1;
                            o_result = '{bspd_pkg::KIND_BINARY, 8'h00, 1'b0, 1'b1};
                        end else begin
                            n_mode = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    n_rem    = r_rem - 32'd1;
                    o_push   = 1'b1;
                    o_result = '{bspd_pkg::KIND_BINARY, i_in_byte, 1'b1, (n_rem == '0)};
                    if (n_rem == '0) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_TEXT: begin
                    if (r_fill < FILL_W'(bspd_pkg::WIN_DEPTH)) begin
                        n_win[r_fill] = i_in_byte;
                        n_fill        = r_fill + FILL_W'(1);
                    end else if (seq == r_term) begin
                        // terminator found: drop it, send a bare end marker
                        n_mode   = MODE_IDLE;
                        n_fill   = '0;
                        n_win    = '{default: 8'h00};
                        o_push   = 1'b1;
                        o_result = '{bspd_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1};
                    end else begin
                        n_win[0] = r_win[1];
                        n_win[1] = r_win[2];
                        n_win[2] = i_in_byte;
                        o_push   = 1'b1;
                        o_result = '{bspd_pkg::KIND_TEXT, r_win[0], 1'b1, 1'b0};
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= bspd_pkg::TERM_RESET;
            r_mode <= MODE_IDLE;
            r_hc   <= '0;
            r_rem  <= '0;
            r_win  <= '{default: 8'h00};
            r_fill <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_term <= i_cfg_data;
            end
            r_mode <= n_mode;
            r_hc   <= n_hc;
            r_rem  <= n_rem;
            r_win  <= n_win;
            r_fill <= n_fill;
        end
    end

endmodule

@@ design/bspd_queue.sv @@
// Short result queue between the framing front end and the output stage.
// Uses bspd_pkg for depth and the result word type.
module bspd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bspd_pkg::t_result       i_data,
    input  logic                    i_pop,
    output bspd_pkg::t_result       o_data,
    output bspd_pkg::t_queue_status o_status
);
    bspd_pkg::t_result                r_mem [bspd_pkg::QUEUE_DEPTH];
    logic [bspd_pkg::QPTR_W-1:0]      r_wptr, r_rptr;
    logic [bspd_pkg::QCNT_W-1:0]      r_count;
    logic                             do_push, do_pop;

    assign o_status.full  = (r_count == bspd_pkg::QCNT_W'(bspd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + bspd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + bspd_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + bspd_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - bspd_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/bspd_back.sv @@
// Output stage of the deframer: registered result word under valid/ready.
// Uses bspd_pkg; pulls words from the queue whenever its register is free or being taken.
module bspd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bspd_pkg::t_queue_status i_q_status,
    input  bspd_pkg::t_result       i_q_data,
    output logic                    o_pop,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output bspd_pkg::t_result       o_out_data
);
    logic              r_valid;
    bspd_pkg::t_result r_data;

    assign o_pop       = !i_q_status.empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_out_ready) begin
            r_valid <= !i_q_status.empty;
        end
    end

    // hold the word while the sink stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

@@ design/bspd_checker.sv @@
// Port-level checks for the deframer result channel, bound to the top level.
// Depends only on the top-level ports of byte_stream_packet_deframer_top.
module bspd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_packet_kind,
    input logic [7:0] i_payload_byte,
    input logic       i_byte_valid,
    input logic       i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_packet_kind)
            && $stable(i_payload_byte) && $stable(i_byte_valid) && $stable(i_last))
        else $error("result word changed while stalled");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_last)
        else $error("bare end marker without last");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_payload_byte == 8'h00)
        else $error("bare end marker carries a nonzero byte");

    a_text_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_packet_kind && i_byte_valid |-> !i_last)
        else $error("text payload byte flagged last");

endmodule

bind byte_stream_packet_deframer_top bspd_checker u_bspd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_packet_kind (o_out.packet_kind),
    .i_payload_byte(o_out.payload_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_last        (o_out.last)
);
